/* rtl/rate_limited_packet_fifo_macros.svh */
// Assertion macros of the rate-limited packet FIFO, used by rlpf_back.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef RATE_LIMITED_PACKET_FIFO_MACROS_SVH
`define RATE_LIMITED_PACKET_FIFO_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define RLPF_ASSERT_HOLDS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its cause.
`define RLPF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// A consequence that must hold in the cycle after its cause.
`define RLPF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/rlpf_pkg.sv */
// Package of the rate-limited packet FIFO: codes, fixed widths, reset values
// and the configuration structure. No dependencies.
`timescale 1ns / 1ps

package rlpf_pkg;

  // Fixed widths of the configuration registers and the running totals.
  localparam int RATE_W     = 24;
  localparam int PCAP_W     = 7;
  localparam int DCAP_W     = 23;
  localparam int BITS_W     = 23;
  localparam int ELAPSED_W  = 32;
  localparam int FRAC_W     = 8;
  localparam int ACTION_W   = 2;
  localparam int STATUS_W   = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_RATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_PCAP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_DCAP = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [RATE_W-1:0] RATE_RESET = 24'd256;
  localparam logic [PCAP_W-1:0] PCAP_RESET = 7'd64;
  localparam logic [DCAP_W-1:0] DCAP_RESET = 23'd8388607;

  // Action codes as they arrive on the input word.
  localparam logic [ACTION_W-1:0] ACT_TICK  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_PUSH  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_PULL  = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_FLUSH = 2'd3;

  // Decoded command carried from the front end to the execution side.
  typedef enum logic [1:0] {
    CMD_TICK,
    CMD_PUSH,
    CMD_PULL,
    CMD_FLUSH
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_TICK      = 3'd0,
    ST_PUSHED    = 3'd1,
    ST_REFUSED   = 3'd2,
    ST_PULLED    = 3'd3,
    ST_EMPTY     = 3'd4,
    ST_TOO_EARLY = 3'd5,
    ST_FLUSHED   = 3'd6
  } status_e;

  typedef struct packed {
    logic [RATE_W-1:0] rate;
    logic [PCAP_W-1:0] pcap;
    logic [DCAP_W-1:0] dcap;
  } cfg_t;

endpackage

/* rtl/rlpf_front.sv */
// Front end of the rate-limited packet FIFO: accepts input words, decodes the
// action and holds the decoded commands in a two-entry queue. Uses rlpf_pkg.
`timescale 1ns / 1ps

module rlpf_front #(
  parameter int LENGTH_BITS = 17,
  parameter int HANDLE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [rlpf_pkg::ACTION_W-1:0] action_i,
  input  logic [LENGTH_BITS-1:0]        packet_length_i,
  input  logic [HANDLE_BITS-1:0]        packet_handle_i,
  output logic                          cmd_valid_o,
  input  logic                          cmd_ready_i,
  output rlpf_pkg::cmd_e                cmd_o,
  output logic [LENGTH_BITS-1:0]        cmd_length_o,
  output logic [HANDLE_BITS-1:0]        cmd_handle_o
);
  import rlpf_pkg::*;

  localparam logic [1:0] FQ_DEPTH = 2'd2;

  cmd_e                   ent_cmd_q    [2];
  logic [LENGTH_BITS-1:0] ent_length_q [2];
  logic [HANDLE_BITS-1:0] ent_handle_q [2];
  logic                   wr_ptr_q, wr_ptr_d;
  logic                   rd_ptr_q, rd_ptr_d;
  logic [1:0]             count_q, count_d;
  cmd_e                   decoded;
  logic                   push, pop;

  always_comb begin
    unique case (action_i)
      ACT_TICK:  decoded = CMD_TICK;
      ACT_PUSH:  decoded = CMD_PUSH;
      ACT_PULL:  decoded = CMD_PULL;
      ACT_FLUSH: decoded = CMD_FLUSH;
      default:   decoded = CMD_TICK;
    endcase
  end

  assign in_ready_o  = (count_q != FQ_DEPTH);
  assign push        = in_valid_i && in_ready_o;
  assign cmd_valid_o = (count_q != 2'd0);
  assign pop         = cmd_valid_o && cmd_ready_i;

  assign cmd_o        = ent_cmd_q[rd_ptr_q];
  assign cmd_length_o = ent_length_q[rd_ptr_q];
  assign cmd_handle_o = ent_handle_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_cmd_q[wr_ptr_q]    <= decoded;
      ent_length_q[wr_ptr_q] <= packet_length_i;
      ent_handle_q[wr_ptr_q] <= packet_handle_i;
    end
  end

endmodule

/* rtl/rlpf_back.sv */
// Execution side of the rate-limited packet FIFO: descriptor memory, queue
// pointers and totals, departure test and the result register. Uses rlpf_pkg.
`timescale 1ns / 1ps
`include "rate_limited_packet_fifo_macros.svh"

module rlpf_back #(
  parameter int QUEUE_DEPTH = 64,
  parameter int LENGTH_BITS = 17,
  parameter int HANDLE_BITS = 16,
  localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rlpf_pkg::cfg_t                cfg_i,
  input  logic                          cfg_we_i,
  input  logic                          cmd_valid_i,
  output logic                          cmd_ready_o,
  input  rlpf_pkg::cmd_e                cmd_i,
  input  logic [LENGTH_BITS-1:0]        cmd_length_i,
  input  logic [HANDLE_BITS-1:0]        cmd_handle_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output rlpf_pkg::status_e             status_o,
  output logic [HANDLE_BITS-1:0]        out_handle_o,
  output logic [LENGTH_BITS-1:0]        out_length_o,
  output logic [CNT_W-1:0]              queued_packets_o,
  output logic [rlpf_pkg::BITS_W-1:0]   queued_bits_o
);
  import rlpf_pkg::*;

  localparam int IDX_W   = $clog2(QUEUE_DEPTH);
  localparam int CMP_W   = (CNT_W > PCAP_W) ? CNT_W : PCAP_W;
  localparam int SUM_W   = ((BITS_W > LENGTH_BITS) ? BITS_W : LENGTH_BITS) + 1;
  localparam int ALLOW_W = ELAPSED_W + RATE_W;

  typedef struct packed {
    logic [HANDLE_BITS-1:0] handle;
    logic [LENGTH_BITS-1:0] length;
  } slot_t;

  slot_t                  mem_q [QUEUE_DEPTH];
  slot_t                  head_rd_q;
  logic [ALLOW_W-1:0]     allow_q;

  logic [IDX_W-1:0]       head_q, head_d;
  logic [IDX_W-1:0]       tail_q, tail_d;
  logic [CNT_W-1:0]       held_count_q, held_count_d;
  logic [BITS_W-1:0]      held_bits_q, held_bits_d;
  logic [ELAPSED_W-1:0]   elapsed_q, elapsed_d;
  logic                   stale_q;

  logic                   out_valid_q, out_valid_d;
  status_e                status_q, status_d;
  logic [HANDLE_BITS-1:0] out_handle_q, out_handle_d;
  logic [LENGTH_BITS-1:0] out_length_q, out_length_d;

  logic                   exec;
  logic                   room_count, room_bits, too_early, pull_ok;
  logic                   mem_we;
  logic [ALLOW_W-1:0]     need;
  logic [IDX_W-1:0]       head_next, tail_next;

  // The product and the head read are both registered from the state, so a
  // command executes only when neither an execution nor a configuration
  // write happened in the previous cycle.
  assign exec        = cmd_valid_i && !stale_q && (!out_valid_q || out_ready_i);
  assign cmd_ready_o = exec;

  assign head_next = (head_q == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
  assign tail_next = (tail_q == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;

  assign room_count = (CMP_W'(held_count_q) < CMP_W'(cfg_i.pcap)) &&
                      (held_count_q < CNT_W'(QUEUE_DEPTH));
  assign room_bits  = (held_bits_q <= cfg_i.dcap) &&
                      (SUM_W'(cfg_i.dcap - held_bits_q) >= SUM_W'(cmd_length_i));

  assign need      = ALLOW_W'({head_rd_q.length, {FRAC_W{1'b0}}});
  assign too_early = (need > allow_q);
  assign pull_ok   = (cmd_i == CMD_PULL) && (held_count_q != '0) && !too_early;
  assign mem_we    = exec && (cmd_i == CMD_PUSH) && room_count && room_bits;

  always_comb begin
    head_d       = head_q;
    tail_d       = tail_q;
    held_count_d = held_count_q;
    held_bits_d  = held_bits_q;
    elapsed_d    = elapsed_q;
    status_d     = status_q;
    out_handle_d = out_handle_q;
    out_length_d = out_length_q;
    if (exec) begin
      out_handle_d = '0;
      out_length_d = '0;
      unique case (cmd_i)
        CMD_TICK: begin
          status_d = ST_TICK;
          if (elapsed_q != '1) begin
            elapsed_d = elapsed_q + 1'b1;
          end
        end
        CMD_PUSH: begin
          if (room_count && room_bits) begin
            status_d     = ST_PUSHED;
            tail_d       = tail_next;
            held_count_d = held_count_q + 1'b1;
            held_bits_d  = BITS_W'(SUM_W'(held_bits_q) + SUM_W'(cmd_length_i));
          end else begin
            status_d = ST_REFUSED;
          end
        end
        CMD_PULL: begin
          if (held_count_q == '0) begin
            status_d = ST_EMPTY;
          end else if (too_early) begin
            status_d = ST_TOO_EARLY;
          end else begin
            status_d     = ST_PULLED;
            out_handle_d = head_rd_q.handle;
            out_length_d = head_rd_q.length;
            head_d       = head_next;
            held_count_d = held_count_q - 1'b1;
            held_bits_d  = (SUM_W'(held_bits_q) >= SUM_W'(head_rd_q.length)) ?
                           BITS_W'(SUM_W'(held_bits_q) - SUM_W'(head_rd_q.length)) : '0;
            elapsed_d    = '0;
          end
        end
        CMD_FLUSH: begin
          status_d     = ST_FLUSHED;
          head_d       = '0;
          tail_d       = '0;
          held_count_d = '0;
          held_bits_d  = '0;
        end
        default: begin
          status_d = ST_TICK;
        end
      endcase
    end
  end

  always_comb begin
    if (exec) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q       <= '0;
      tail_q       <= '0;
      held_count_q <= '0;
      held_bits_q  <= '0;
      elapsed_q    <= '0;
      stale_q      <= 1'b1;
      out_valid_q  <= 1'b0;
    end else begin
      head_q       <= head_d;
      tail_q       <= tail_d;
      held_count_q <= held_count_d;
      held_bits_q  <= held_bits_d;
      elapsed_q    <= elapsed_d;
      stale_q      <= exec || cfg_we_i;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q     <= status_d;
    out_handle_q <= out_handle_d;
    out_length_q <= out_length_d;
    allow_q      <= ALLOW_W'(elapsed_q) * ALLOW_W'(cfg_i.rate);
  end

  // Descriptor memory: one write port at the tail, one registered read at the head.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[tail_q] <= '{handle: cmd_handle_i, length: cmd_length_i};
    end
    head_rd_q <= mem_q[head_q];
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign out_handle_o     = out_handle_q;
  assign out_length_o     = out_length_q;
  assign queued_packets_o = held_count_q;
  assign queued_bits_o    = held_bits_q;

  `RLPF_ASSERT_HOLDS(a_count_in_depth, held_count_q <= CNT_W'(QUEUE_DEPTH), "count above depth")
  `RLPF_ASSERT_IMP(a_empty_no_bits, held_count_q == '0, held_bits_q == '0, "bits left in empty queue")
  `RLPF_ASSERT_NEXT(a_exec_spaced, exec, !exec, "commands executed in consecutive cycles")
  `RLPF_ASSERT_NEXT(a_pull_restarts, exec && pull_ok, elapsed_q == '0, "elapsed not restarted")

endmodule

/* rtl/rate_limited_packet_fifo.sv */
// Top level of the rate-limited packet FIFO: configuration registers, front
// end and execution side. Depends on rlpf_pkg, rlpf_front and rlpf_back.
//
//   channel   direction   handshake                  word
//   input     in          in_valid_i / in_ready_o    action, packet length, packet handle
//   output    out         out_valid_o / out_ready_i  status, handle, length, totals
//   config    in          cfg_we_i (no wait)         register index, write data
//
// Each word executes in the execution side, after which the registered
// elapsed-times-rate product and the registered head read of the descriptor
// memory catch up with the new state before the next word executes. A word's
// result appears on the output in the cycle after it leaves the two-entry front
// queue. A configuration write likewise holds off the next execution for the
// same reason. Reset clears the queue, totals and elapsed counter at once; the
// descriptor memory needs no clearing. A stalled output blocks execution,
// while the front queue keeps taking up to two more words.
`timescale 1ns / 1ps

module rate_limited_packet_fifo #(
  parameter int QUEUE_DEPTH = 64,
  parameter int LENGTH_BITS = 17,
  parameter int HANDLE_BITS = 16,
  localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [rlpf_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [rlpf_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [rlpf_pkg::ACTION_W-1:0]   action_i,
  input  logic [LENGTH_BITS-1:0]          packet_length_i,
  input  logic [HANDLE_BITS-1:0]          packet_handle_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [rlpf_pkg::STATUS_W-1:0]   status_o,
  output logic [HANDLE_BITS-1:0]          out_handle_o,
  output logic [LENGTH_BITS-1:0]          out_length_o,
  output logic [CNT_W-1:0]                queued_packets_o,
  output logic [rlpf_pkg::BITS_W-1:0]     queued_bits_o
);
  import rlpf_pkg::*;

  cfg_t                   cfg_q, cfg_d;
  logic                   cmd_valid, cmd_ready;
  cmd_e                   cmd;
  logic [LENGTH_BITS-1:0] cmd_length;
  logic [HANDLE_BITS-1:0] cmd_handle;
  status_e                status;

  // Configuration registers. Writes to an index beyond the list are dropped.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_IDX_RATE: cfg_d.rate = cfg_wdata_i[RATE_W-1:0];
        CFG_IDX_PCAP: cfg_d.pcap = cfg_wdata_i[PCAP_W-1:0];
        CFG_IDX_DCAP: cfg_d.dcap = cfg_wdata_i[DCAP_W-1:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{rate: RATE_RESET, pcap: PCAP_RESET, dcap: DCAP_RESET};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // The front end decodes the action and buffers commands so that input
  // words keep flowing while the execution side waits on the output.
  rlpf_front #(
    .LENGTH_BITS (LENGTH_BITS),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .action_i        (action_i),
    .packet_length_i (packet_length_i),
    .packet_handle_i (packet_handle_i),
    .cmd_valid_o     (cmd_valid),
    .cmd_ready_i     (cmd_ready),
    .cmd_o           (cmd),
    .cmd_length_o    (cmd_length),
    .cmd_handle_o    (cmd_handle)
  );

  // The execution side owns the descriptor memory, the departure test and
  // the result register.
  rlpf_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .LENGTH_BITS (LENGTH_BITS),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .cfg_we_i         (cfg_we_i),
    .cmd_valid_i      (cmd_valid),
    .cmd_ready_o      (cmd_ready),
    .cmd_i            (cmd),
    .cmd_length_i     (cmd_length),
    .cmd_handle_i     (cmd_handle),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status),
    .out_handle_o     (out_handle_o),
    .out_length_o     (out_length_o),
    .queued_packets_o (queued_packets_o),
    .queued_bits_o    (queued_bits_o)
  );

  assign status_o = status;

endmodule

/* bench/tb_top.sv */
// Self-checking testbench for rate_limited_packet_fifo. It drives words of ticks, pushes,
// pulls and flushes through the valid/ready channels and checks every result word.
// Depends on rlpf_pkg and the rate_limited_packet_fifo RTL.
`timescale 1ns / 1ps

module tb_top;
  import rlpf_pkg::*;

  localparam int DEPTH       = 64;
  localparam int LEN_W       = 17;
  localparam int HND_W       = 16;
  localparam int CNT_W       = 7;
  localparam int LEN_MAX     = 131071;
  localparam int LONG_HOLD   = 300;
  localparam int CYCLE_LIMIT = 1000000;

  // One result word as the block should report it.
  typedef struct {
    status_e            status;
    logic [HND_W-1:0]   handle;
    logic [LEN_W-1:0]   length;
    logic [CNT_W-1:0]   packets;
    logic [BITS_W-1:0]  bits;
  } fifo_result_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [ACTION_W-1:0]   action_i;
  logic [LEN_W-1:0]      packet_length_i;
  logic [HND_W-1:0]      packet_handle_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [STATUS_W-1:0]   status_o;
  logic [HND_W-1:0]      out_handle_o;
  logic [LEN_W-1:0]      out_length_o;
  logic [CNT_W-1:0]      queued_packets_o;
  logic [BITS_W-1:0]     queued_bits_o;

  // Mirror of the shaper: configuration, descriptor ring and running totals.
  logic [RATE_W-1:0]  rate_cfg;
  logic [PCAP_W-1:0]  pcap_cfg;
  logic [DCAP_W-1:0]  dcap_cfg;
  logic [HND_W-1:0]   ring_handle [DEPTH];
  logic [LEN_W-1:0]   ring_length [DEPTH];
  int unsigned        ring_head;
  int unsigned        ring_tail;
  int unsigned        held_count;
  int unsigned        held_bits;
  int unsigned        elapsed_ticks;

  fifo_result_t pending_results[$];
  int           error_count;
  int           cycle_count;

  // Knobs that the test tasks turn to shape the traffic on both channels.
  bit tx_steady;
  bit rx_steady;
  bit long_hold_req;

  rate_limited_packet_fifo dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .action_i         (action_i),
    .packet_length_i  (packet_length_i),
    .packet_handle_i  (packet_handle_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .out_handle_o     (out_handle_o),
    .out_length_o     (out_length_o),
    .queued_packets_o (queued_packets_o),
    .queued_bits_o    (queued_bits_o)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // Idle stretch length: most of the time none, often a short one and now and then a
  // long one, so that gaps land on every stage of the block.
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Computes the result word of one accepted word and advances the mirrored state.
  function automatic fifo_result_t shaper_predict(input logic [ACTION_W-1:0] act,
                                                  input logic [LEN_W-1:0] len,
                                                  input logic [HND_W-1:0] hnd);
    fifo_result_t      res;
    int unsigned       pkt_limit;
    longint unsigned   need_bits;
    longint unsigned   allowed_bits;
    res.status = ST_TICK;
    res.handle = '0;
    res.length = '0;
    case (act)
      ACT_TICK: begin
        if (elapsed_ticks != 32'hFFFF_FFFF) elapsed_ticks++;
        res.status = ST_TICK;
      end
      ACT_PUSH: begin
        // A capacity above the ring depth adds no limit of its own.
        pkt_limit = (pcap_cfg > DEPTH) ? DEPTH : pcap_cfg;
        if (held_count >= pkt_limit || held_bits > dcap_cfg ||
            dcap_cfg - held_bits < len) begin
          res.status = ST_REFUSED;
        end else begin
          ring_handle[ring_tail] = hnd;
          ring_length[ring_tail] = len;
          ring_tail = (ring_tail + 1) % DEPTH;
          held_count++;
          held_bits += len;
          res.status = ST_PUSHED;
        end
      end
      ACT_PULL: begin
        if (held_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          // The rate carries 8 fraction bits, so the length is scaled to match.
          need_bits    = longint'(ring_length[ring_head]) << FRAC_W;
          allowed_bits = longint'(elapsed_ticks) * longint'(rate_cfg);
          if (need_bits > allowed_bits) begin
            res.status = ST_TOO_EARLY;
          end else begin
            res.handle = ring_handle[ring_head];
            res.length = ring_length[ring_head];
            ring_head = (ring_head + 1) % DEPTH;
            held_count--;
            held_bits = (held_bits >= res.length) ? held_bits - res.length : 0;
            elapsed_ticks = 0;
            res.status = ST_PULLED;
          end
        end
      end
      default: begin
        ring_head  = 0;
        ring_tail  = 0;
        held_count = 0;
        held_bits  = 0;
        res.status = ST_FLUSHED;
      end
    endcase
    res.packets = held_count[CNT_W-1:0];
    res.bits    = held_bits[BITS_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH at %0t: %s got %0d want %0d", $realtime, what, got, want);
    error_count++;
  endtask

  // Offers one word and waits for the handshake. The valid stays high afterward
  // unless an idle gap follows, so back-to-back words never drop valid.
  task automatic send_word(input logic [ACTION_W-1:0] act, input logic [LEN_W-1:0] len,
                           input logic [HND_W-1:0] hnd);
    int gap;
    @(negedge clk_i);
    action_i        = act;
    packet_length_i = len;
    packet_handle_i = hnd;
    in_valid_i      = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.insert(pending_results.size(), shaper_predict(act, len, hnd));
    gap = tx_steady ? 0 : idle_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  // Stops offering words and waits until every expected result word has been seen,
  // then lets the execution side settle.
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Writes one register. Only called while no word is in flight.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_wdata_i = data;
    case (idx)
      CFG_IDX_RATE: rate_cfg = data[RATE_W-1:0];
      CFG_IDX_PCAP: pcap_cfg = data[PCAP_W-1:0];
      CFG_IDX_DCAP: dcap_cfg = data[DCAP_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic set_limits(input int rate, input int pcap, input int dcap);
    wait_idle();
    write_reg(CFG_IDX_RATE, CFG_DATA_W'(rate));
    write_reg(CFG_IDX_PCAP, CFG_DATA_W'(pcap));
    write_reg(CFG_IDX_DCAP, CFG_DATA_W'(dcap));
  endtask

  // Random words drawn by weight. Lengths hit zero and the top of the range often.
  task automatic run_traffic(input int words, input int push_w, input int pull_w,
                             input int tick_w, input int flush_w, input int len_top);
    int                  r;
    logic [ACTION_W-1:0] act;
    logic [LEN_W-1:0]    len;
    repeat (words) begin
      r = $urandom_range(0, push_w + pull_w + tick_w + flush_w - 1);
      if (r < push_w) act = ACT_PUSH;
      else if (r < push_w + pull_w) act = ACT_PULL;
      else if (r < push_w + pull_w + tick_w) act = ACT_TICK;
      else act = ACT_FLUSH;
      r = $urandom_range(0, 9);
      if (r == 0) len = '0;
      else if (r == 1) len = LEN_W'(len_top);
      else len = LEN_W'($urandom_range(0, len_top));
      send_word(act, len, HND_W'($urandom));
    end
  endtask

  // Every action at the reset settings: empty pull, extreme lengths and handles,
  // a zero-length pull with no ticks, a too-early pull, ticks and a flush.
  task automatic test_basic_actions();
    send_word(ACT_PULL, '0, '0);
    send_word(ACT_PUSH, '0, 16'hFFFF);
    send_word(ACT_PUSH, LEN_W'(LEN_MAX), '0);
    send_word(ACT_PULL, LEN_W'(LEN_MAX), 16'hFFFF);
    send_word(ACT_PULL, '0, '0);
    send_word(ACT_TICK, LEN_W'(LEN_MAX), 16'hFFFF);
    send_word(ACT_TICK, '0, '0);
    send_word(ACT_FLUSH, LEN_W'(LEN_MAX), 16'hFFFF);
  endtask

  // With a zero rate only zero-length packets leave; the minimum nonzero rate
  // still holds back a one-bit packet after a single tick.
  task automatic test_zero_rate();
    set_limits(0, 64, 8388607);
    send_word(ACT_PUSH, '0, 16'h1234);
    send_word(ACT_PUSH, LEN_W'(1), 16'h4321);
    send_word(ACT_TICK, '0, '0);
    send_word(ACT_PULL, '0, '0);
    send_word(ACT_PULL, '0, '0);
    wait_idle();
    write_reg(CFG_IDX_RATE, CFG_DATA_W'(1));
    send_word(ACT_TICK, '0, '0);
    send_word(ACT_PULL, '0, '0);
    send_word(ACT_FLUSH, '0, '0);
  endtask

  // Packet and bit limits, a packet limit lowered under the contents, a zero bit
  // limit, a zero packet limit and a packet limit above the ring depth.
  task automatic test_capacity_limits();
    set_limits(16777215, 2, 100);
    send_word(ACT_PUSH, LEN_W'(60), 16'h00AA);
    send_word(ACT_PUSH, LEN_W'(41), 16'h00BB);
    send_word(ACT_PUSH, LEN_W'(40), 16'h00CC);
    send_word(ACT_PUSH, '0, 16'h00DD);
    wait_idle();
    write_reg(CFG_IDX_PCAP, CFG_DATA_W'(1));
    send_word(ACT_PUSH, '0, 16'h00EE);
    send_word(ACT_TICK, '0, '0);
    send_word(ACT_PULL, '0, '0);
    send_word(ACT_PUSH, '0, 16'h00EE);
    send_word(ACT_TICK, '0, '0);
    send_word(ACT_PULL, '0, '0);
    send_word(ACT_PUSH, LEN_W'(7), 16'h00FF);
    set_limits(16777215, 127, 0);
    send_word(ACT_PUSH, '0, 16'h5555);
    send_word(ACT_PUSH, LEN_W'(1), 16'hAAAA);
    wait_idle();
    write_reg(CFG_IDX_PCAP, CFG_DATA_W'(0));
    send_word(ACT_PUSH, '0, 16'h0F0F);
    send_word(ACT_FLUSH, '0, '0);
  endtask

  // The receiver holds off for a long stretch while words keep coming, so the
  // block fills and drops its ready; then the sender waits for every result.
  task automatic test_backpressure();
    set_limits(16777215, 64, 8388607);
    tx_steady     = 1'b1;
    long_hold_req = 1'b1;
    run_traffic(16, 4, 3, 3, 0, LEN_MAX);
    tx_steady = 1'b0;
    wait_idle();
  endtask

  // A push-heavy run with the packet limit above the depth, so the ring fills
  // to its full depth and further pushes are refused.
  task automatic test_fill_to_depth();
    set_limits(16777215, 127, 8388607);
    run_traffic(90, 18, 1, 1, 0, LEN_MAX);
    send_word(ACT_FLUSH, '0, '0);
  endtask

  // Several settings in turn, each with its own mix of words.
  task automatic test_random_settings();
    // Fast link, default limits, no idling on either side.
    set_limits(16777215, 64, 8388607);
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    run_traffic(160, 4, 3, 3, 1, LEN_MAX);
    wait_idle();
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    // Random settings over their whole ranges, but for a zero rate and packet limits above the ring depth.
    set_limits($urandom_range(1, 16777215), $urandom_range(0, 64),
               $urandom_range(0, 8388607));
    run_traffic(160, 4, 3, 3, 1, LEN_MAX);
    // Slow rate with short packets, so pulls often come too early.
    set_limits(32, 64, 8388607);
    run_traffic(160, 2, 3, 5, 1, 15);
    // Tight bit budget, moderate rate.
    set_limits($urandom_range(256, 65536), 64, $urandom_range(0, 300000));
    run_traffic(160, 5, 2, 3, 1, LEN_MAX);
    // Small packet limit with mid-sized packets.
    set_limits(256 * 64, 3, 8388607);
    run_traffic(160, 4, 3, 3, 1, 8191);
  endtask

  // Receiver: random stalls, a steady mode and the long hold-off on request.
  initial begin : receiver
    int hold;
    int gap;
    hold        = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold          = LONG_HOLD;
      end
      if (hold > 0) begin
        out_ready_i = 1'b0;
        hold--;
      end else if (rx_steady) begin
        out_ready_i = 1'b1;
      end else begin
        gap = idle_gap();
        out_ready_i = (gap == 0);
        if (gap > 0) hold = gap - 1;
      end
    end
  end

  // Checks each result word against the oldest expectation, field by field.
  always @(posedge clk_i) begin : check_results
    fifo_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result word with none expected, status", status_o, 0);
      end else begin
        want = pending_results.pop_front();
        if (status_o !== want.status) report_mismatch("status", status_o, want.status);
        if (out_handle_o !== want.handle) report_mismatch("handle", out_handle_o, want.handle);
        if (out_length_o !== want.length) report_mismatch("length", out_length_o, want.length);
        if (queued_packets_o !== want.packets)
          report_mismatch("queued packets", queued_packets_o, want.packets);
        if (queued_bits_o !== want.bits)
          report_mismatch("queued bits", queued_bits_o, want.bits);
      end
    end
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("rate_limited_packet_fifo regression: fail");
    $finish;
  end

  initial begin : main_sequence
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_index_i     = '0;
    cfg_wdata_i     = '0;
    in_valid_i      = 1'b0;
    action_i        = ACT_TICK;
    packet_length_i = '0;
    packet_handle_i = '0;
    tx_steady       = 1'b0;
    rx_steady       = 1'b0;
    long_hold_req   = 1'b0;
    error_count     = 0;
    rate_cfg        = RATE_RESET;
    pcap_cfg        = PCAP_RESET;
    dcap_cfg        = DCAP_RESET;
    ring_head       = 0;
    ring_tail       = 0;
    held_count      = 0;
    held_bits       = 0;
    elapsed_ticks   = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_basic_actions();
    test_zero_rate();
    test_capacity_limits();
    test_backpressure();
    test_fill_to_depth();
    test_random_settings();

    wait_idle();
    repeat (8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("rate_limited_packet_fifo regression: pass");
    end else begin
      $display("rate_limited_packet_fifo regression: fail");
    end
    $finish;
  end

endmodule
